FILE: src/swrm_pkg.sv
// Shared types, constants and helpers of the sliding-window rate monitor.
package swrm_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int TS_W        = 32;
  localparam int RATE_W      = 40;
  localparam int FRAC_W      = 16;
  localparam int COUNT_W     = 11;
  localparam int PROD_W      = RATE_W + FRAC_W;

  // 1e9 milli-hertz per event per tick fits in 30 bits
  localparam int TICK_W      = 30;
  localparam logic [TICK_W-1:0] TICK_MHZ = TICK_W'(1000000000);
  localparam int NUM_W       = CNT_W + TICK_W;
  localparam int DIV_CNT_W   = $clog2(NUM_W);

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = RATE_W;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION = 2'd2;

  localparam logic [TS_W-1:0] WINDOW_RESET = TS_W'(1000000);

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef logic [TS_W-1:0]  ts_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PUSH,
    ST_PRUNE_RD,
    ST_PRUNE_CMP,
    ST_EVAL,
    ST_SPAN,
    ST_DIV,
    ST_ALARM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    ts_t              denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // ring index idx + k, wrapped at the store depth
  function automatic idx_t ring_add(input idx_t idx, input cnt_t k);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(idx) + (CNT_W + 1)'(k);
    if (sum >= (CNT_W + 1)'(STORE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(STORE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: src/swrm_if.sv
// Handshake channels of the rate monitor: sample input, result output, register writes.
interface swrm_in_if;
  import swrm_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  ts_t  timestamp;
  modport source (output valid, output kind, output timestamp, input ready);
  modport sink (input valid, input kind, input timestamp, output ready);
endinterface

interface swrm_out_if;
  import swrm_pkg::*;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [COUNT_W-1:0] sample_count;
  logic               full_window;
  logic [RATE_W-1:0]  rate_mhz;
  logic               below_nominal;
  modport source (output valid, output accepted, output sample_count, output full_window,
                  output rate_mhz, output below_nominal, input ready);
  modport sink (input valid, input accepted, input sample_count, input full_window,
                input rate_mhz, input below_nominal, output ready);
endinterface

interface swrm_cfg_if;
  import swrm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/sliding_window_rate_monitor_core.sv
// Sliding-window event rate monitor: top level with register file and sequencer.
// Each item is a sample timestamp (microsecond ticks) or a clear command. Timestamps
// are kept in a 1024-entry ring RAM; a repeat of the newest is rejected, an older one
// restarts the store, and samples that fall out of the window are pruned. Every item
// gives one result: accepted, sample count, full-window flag, rate in milli-hertz and
// a below-nominal alarm. The block takes one item at a time. A full window runs the
// 41-step restoring divider (one quotient bit a cycle). The prune loop reads one stored
// sample at a time through the RAM read port. A new item is taken while the previous
// result still waits on the output register; the block then holds its next result until
// that one is taken.
// Registers may be written only while the block is idle.
module sliding_window_rate_monitor_core (
  input logic        clk,
  input logic        rst,
  swrm_in_if.sink    sample_in,
  swrm_out_if.source result,
  swrm_cfg_if.sink   cfg
);
  import swrm_pkg::*;

  // configuration
  ts_t                window_ticks;
  logic [RATE_W-1:0]  nominal_rate_mhz;
  logic [FRAC_W-1:0]  fraction_q16;

  // sequencer state
  state_t state, state_next;
  cnt_t   held, held_next;
  idx_t   oldest, oldest_next;
  ts_t    newest, newest_next;
  ts_t    ts_q, ts_q_next;
  logic   kind_q, kind_q_next;
  logic   acc_q, acc_q_next;
  logic   full_q, full_q_next;
  logic   below_q, below_q_next;
  logic [RATE_W-1:0] rate_q, rate_q_next;
  logic [NUM_W-1:0]  num_q, num_q_next;
  logic [PROD_W-1:0] prod_q, prod_q_next;

  // result register
  logic               out_valid, out_valid_next;
  logic               out_acc, out_acc_next;
  logic [COUNT_W-1:0] out_count, out_count_next;
  logic               out_full, out_full_next;
  logic [RATE_W-1:0]  out_rate, out_rate_next;
  logic               out_below, out_below_next;

  // RAM and divider
  logic     ram_we;
  idx_t     ram_waddr;
  logic     ram_re;
  idx_t     ram_raddr;
  ts_t      ram_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [TS_W:0] prune_lhs;
  ts_t           span;

  swrm_ram #(
    .WIDTH (TS_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ts_q),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swrm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks     <= WINDOW_RESET;
      nominal_rate_mhz <= '0;
      fraction_q16     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WINDOW:   window_ticks     <= cfg.data[TS_W-1:0];
        REG_NOMINAL:  nominal_rate_mhz <= cfg.data[RATE_W-1:0];
        REG_FRACTION: fraction_q16     <= cfg.data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  assign sample_in.ready      = (state == ST_IDLE);
  assign result.valid         = out_valid;
  assign result.accepted      = out_acc;
  assign result.sample_count  = out_count;
  assign result.full_window   = out_full;
  assign result.rate_mhz      = out_rate;
  assign result.below_nominal = out_below;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      held      <= '0;
      oldest    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      held      <= held_next;
      oldest    <= oldest_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    newest    <= newest_next;
    ts_q      <= ts_q_next;
    kind_q    <= kind_q_next;
    acc_q     <= acc_q_next;
    full_q    <= full_q_next;
    below_q   <= below_q_next;
    rate_q    <= rate_q_next;
    num_q     <= num_q_next;
    prod_q    <= prod_q_next;
    out_acc   <= out_acc_next;
    out_count <= out_count_next;
    out_full  <= out_full_next;
    out_rate  <= out_rate_next;
    out_below <= out_below_next;
  end

  always_comb begin
    prune_lhs = (TS_W + 1)'(ram_rdata) + (TS_W + 1)'(window_ticks);
    span      = newest - ram_rdata;

    state_next     = state;
    held_next      = held;
    oldest_next    = oldest;
    newest_next    = newest;
    ts_q_next      = ts_q;
    kind_q_next    = kind_q;
    acc_q_next     = acc_q;
    full_q_next    = full_q;
    below_q_next   = below_q;
    rate_q_next    = rate_q;
    num_q_next     = num_q;
    prod_q_next    = prod_q;
    out_valid_next = out_valid && !result.ready;
    out_acc_next   = out_acc;
    out_count_next = out_count;
    out_full_next  = out_full;
    out_rate_next  = out_rate;
    out_below_next = out_below;

    ram_we        = 1'b0;
    ram_waddr     = ring_add(oldest, held);
    ram_re        = 1'b0;
    ram_raddr     = oldest;
    div_req.start = 1'b0;
    div_req.numer = num_q;
    div_req.denom = span;

    case (state)
      ST_IDLE: begin
        if (sample_in.valid) begin
          ts_q_next   = sample_in.timestamp;
          kind_q_next = sample_in.kind;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        acc_q_next   = 1'b1;
        full_q_next  = 1'b0;
        rate_q_next  = '0;
        below_q_next = 1'b0;
        if (kind_q == KIND_CLEAR) begin
          held_next   = '0;
          oldest_next = '0;
          state_next  = ST_EVAL;
        end else if (held != '0 && ts_q == newest) begin
          acc_q_next = 1'b0;
          state_next = ST_EVAL;
        end else begin
          // going back in time restarts the store
          if (held != '0 && ts_q < newest) begin
            held_next   = '0;
            oldest_next = '0;
          end
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        ram_we      = 1'b1;
        newest_next = ts_q;
        if (held == CNT_W'(STORE_DEPTH)) begin
          // full: overwrite the oldest slot and advance
          ram_waddr   = oldest;
          oldest_next = ring_add(oldest, CNT_W'(1));
        end else begin
          held_next = held + CNT_W'(1);
        end
        state_next = ST_PRUNE_RD;
      end
      ST_PRUNE_RD: begin
        if (held > CNT_W'(2)) begin
          ram_re     = 1'b1;
          ram_raddr  = ring_add(oldest, CNT_W'(1));
          state_next = ST_PRUNE_CMP;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_PRUNE_CMP: begin
        // second-oldest at or before newest - window: drop the oldest
        if (prune_lhs <= (TS_W + 1)'(ts_q)) begin
          oldest_next = ring_add(oldest, CNT_W'(1));
          held_next   = held - CNT_W'(1);
          state_next  = ST_PRUNE_RD;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        num_q_next  = NUM_W'(held - CNT_W'(1)) * NUM_W'(TICK_MHZ);
        prod_q_next = PROD_W'(fraction_q16) * PROD_W'(nominal_rate_mhz);
        if (held >= CNT_W'(2)) begin
          ram_re     = 1'b1;
          ram_raddr  = oldest;
          state_next = ST_SPAN;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_SPAN: begin
        if (newest > ram_rdata && span >= window_ticks) begin
          full_q_next   = 1'b1;
          div_req.start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quot > NUM_W'(RATE_MAX)) begin
            rate_q_next = RATE_MAX;
          end else begin
            rate_q_next = RATE_W'(div_rsp.quot);
          end
          state_next = ST_ALARM;
        end
      end
      ST_ALARM: begin
        below_q_next = (nominal_rate_mhz != '0) && (fraction_q16 != '0) &&
                       ({rate_q, FRAC_W'(0)} < prod_q);
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || result.ready) begin
          out_valid_next = 1'b1;
          out_acc_next   = acc_q;
          out_count_next = COUNT_W'(held);
          out_full_next  = full_q;
          out_rate_next  = rate_q;
          out_below_next = below_q;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/swrm_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module swrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/swrm_div.sv
// Restoring divider, one quotient bit per cycle.
module swrm_div (
  input  logic                clk,
  input  logic                rst,
  input  swrm_pkg::div_req_t  req,
  output swrm_pkg::div_rsp_t  rsp
);
  import swrm_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     q;
  ts_t                  d;
  logic [TS_W:0]        rem;

  logic [TS_W:0] rem_shift;
  logic [TS_W:0] diff;
  logic          fits;

  always_comb begin
    rem_shift = {rem[TS_W-1:0], q[NUM_W-1]};
    diff      = rem_shift - {1'b0, d};
    fits      = (rem_shift >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.numer;
      d   <= req.denom;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? diff : rem_shift;
      q   <= {q[NUM_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the sliding-window rate monitor with its own rate predictor.
module testbench;
  import swrm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned REPORT_CAP   = 50;
  localparam int unsigned RAND_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS  = 40;
  localparam int unsigned FILL_ITEMS   = 1030;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] sample_count;
    logic               full_window;
    logic [RATE_W-1:0]  rate_mhz;
    logic               below_nominal;
  } meter_result_t;

  logic clk = 1'b0;
  logic rst;

  swrm_in_if  sample_if ();
  swrm_out_if result_if ();
  swrm_cfg_if cfg_if ();

  sliding_window_rate_monitor_core u_top (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_if),
    .result    (result_if),
    .cfg       (cfg_if)
  );

  always #4 clk = ~clk;

  // predictor state
  ts_t               ring_ts [STORE_DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_fill;
  ts_t               win_ticks;
  logic [RATE_W-1:0] nominal_mhz;
  logic [FRAC_W-1:0] frac_q16;

  meter_result_t expected_results [$];
  int unsigned   fail_count  = 0;
  int unsigned   cycle_count = 0;
  int unsigned   stall_left  = 0;
  bit            idle_on     = 1'b1;

  function automatic ts_t ring_entry(input int unsigned k);
    return ring_ts[(ring_head + k) % STORE_DEPTH];
  endfunction

  function automatic void drop_first();
    if (ring_fill > 0) begin
      ring_head = (ring_head + 1) % STORE_DEPTH;
      ring_fill--;
    end
  endfunction

  // expected results queue: append at the tail, take from the head
  function automatic void queue_expected(input meter_result_t item);
    expected_results.insert(expected_results.size(), item);
  endfunction

  function automatic meter_result_t take_expected();
    meter_result_t item;
    item = expected_results[0];
    expected_results.delete(0);
    return item;
  endfunction

  function automatic meter_result_t predict_meter(input logic kind, input ts_t ts);
    meter_result_t r;
    ts_t           first;
    ts_t           last;
    logic [63:0]   elapsed;
    logic [63:0]   rate;
    logic          dup;
    r = '0;
    r.accepted = 1'b1;
    dup = 1'b0;
    if (kind == KIND_CLEAR) begin
      ring_head = 0;
      ring_fill = 0;
    end else begin
      if (ring_fill > 0) begin
        last = ring_entry(ring_fill - 1);
        if (ts == last) begin
          dup = 1'b1;
        end else if (ts < last) begin
          ring_head = 0;
          ring_fill = 0;
        end
      end
      if (dup) begin
        r.accepted = 1'b0;
      end else begin
        if (ring_fill >= STORE_DEPTH) drop_first();
        ring_ts[(ring_head + ring_fill) % STORE_DEPTH] = ts;
        ring_fill++;
        // drop leading samples while the second one is already out of the window
        while (ring_fill > 2 &&
               {32'd0, ring_entry(1)} + {32'd0, win_ticks} <= {32'd0, ts}) begin
          drop_first();
        end
      end
    end
    if (ring_fill >= 2) begin
      first = ring_entry(0);
      last = ring_entry(ring_fill - 1);
      elapsed = {32'd0, last - first};
      if (last > first && elapsed >= {32'd0, win_ticks}) begin
        rate = (64'(ring_fill) - 64'd1) * 64'd1000000000 / elapsed;
        if (rate > {24'd0, RATE_MAX}) rate = {24'd0, RATE_MAX};
        r.full_window = 1'b1;
        r.rate_mhz = rate[RATE_W-1:0];
        if (nominal_mhz != 0 && frac_q16 != 0 &&
            (rate << 16) < 64'(frac_q16) * 64'(nominal_mhz)) begin
          r.below_nominal = 1'b1;
        end
      end
    end
    r.sample_count = COUNT_W'(ring_fill);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < REPORT_CAP) begin
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    end
    fail_count++;
  endtask

  task automatic check_result();
    meter_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", 64'(result_if.sample_count), 64'd0);
      return;
    end
    want = take_expected();
    if (result_if.accepted !== want.accepted)
      report_mismatch("accepted", 64'(result_if.accepted), 64'(want.accepted));
    if (result_if.sample_count !== want.sample_count)
      report_mismatch("sample_count", 64'(result_if.sample_count), 64'(want.sample_count));
    if (result_if.full_window !== want.full_window)
      report_mismatch("full_window", 64'(result_if.full_window), 64'(want.full_window));
    if (result_if.rate_mhz !== want.rate_mhz)
      report_mismatch("rate_mhz", 64'(result_if.rate_mhz), 64'(want.rate_mhz));
    if (result_if.below_nominal !== want.below_nominal)
      report_mismatch("below_nominal", 64'(result_if.below_nominal), 64'(want.below_nominal));
  endtask

  // result side: check each result as it is taken, stall at random
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) check_result();
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      result_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      result_if.ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_sample(input logic kind, input ts_t ts);
    int unsigned gap;
    sample_if.valid <= 1'b1;
    sample_if.kind <= kind;
    sample_if.timestamp <= ts;
    do @(posedge clk); while (!sample_if.ready);
    queue_expected(predict_meter(kind, ts));
    gap = pick_gap();
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // lower valid and wait until every expected result has come back
  task automatic finish_phase();
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_WINDOW:   win_ticks = value[TS_W-1:0];
      REG_NOMINAL:  nominal_mhz = value[RATE_W-1:0];
      REG_FRACTION: frac_q16 = value[FRAC_W-1:0];
      default: ;
    endcase
  endtask

  // block must be idle here: callers finish the previous phase first
  task automatic write_regs(input ts_t window, input logic [RATE_W-1:0] nominal,
                            input logic [FRAC_W-1:0] fraction);
    cfg_write(REG_WINDOW, CFG_DATA_W'(window));
    cfg_write(REG_NOMINAL, CFG_DATA_W'(nominal));
    cfg_write(REG_FRACTION, CFG_DATA_W'(fraction));
    cfg_if.valid <= 1'b0;
  endtask

  // reset values: clear on empty, duplicates, older restart, widest span
  task automatic test_defaults();
    send_sample(KIND_CLEAR, $urandom);
    send_sample(KIND_PUSH, 32'd0);
    send_sample(KIND_PUSH, 32'd0);
    send_sample(KIND_PUSH, 32'hFFFF_FFFF);
    send_sample(KIND_PUSH, 32'd5);
    send_sample(KIND_PUSH, 32'd1000005);
    send_sample(KIND_PUSH, 32'd1000005);
    send_sample(KIND_PUSH, 32'd1500005);
    send_sample(KIND_CLEAR, 32'hFFFF_FFFF);
    finish_phase();
  endtask

  task automatic test_register_extremes();
    write_regs(32'd1, RATE_MAX, 16'hFFFF);
    send_sample(KIND_PUSH, 32'd100);
    send_sample(KIND_PUSH, 32'd101);
    send_sample(KIND_PUSH, 32'd102);
    send_sample(KIND_PUSH, 32'd50);
    finish_phase();
    // zero window keeps at most two samples
    write_regs(32'd0, 40'd1, 16'd1);
    send_sample(KIND_PUSH, 32'd10);
    send_sample(KIND_PUSH, 32'd11);
    send_sample(KIND_PUSH, 32'd12);
    send_sample(KIND_PUSH, 32'd13);
    finish_phase();
    write_regs(32'hFFFF_FFFF, '0, '0);
    send_sample(KIND_CLEAR, 32'd0);
    send_sample(KIND_PUSH, 32'd0);
    send_sample(KIND_PUSH, 32'hFFFF_FFFF);
    finish_phase();
    // 3000 lands exactly on the alarm threshold, 20000 falls below it
    write_regs(32'd1000, 40'd1000000, 16'h8000);
    send_sample(KIND_PUSH, 32'd0);
    send_sample(KIND_PUSH, 32'd500);
    send_sample(KIND_PUSH, 32'd1000);
    send_sample(KIND_PUSH, 32'd3000);
    send_sample(KIND_PUSH, 32'd20000);
    finish_phase();
  endtask

  // window wide enough that nothing is pruned, so the ring wraps and overflows
  task automatic test_store_full();
    ts_t ts;
    idle_on = 1'b0;
    write_regs(32'd60000, 40'(64'd1000000000 / 25), 16'(($urandom_range(1, 65535))));
    send_sample(KIND_CLEAR, $urandom);
    ts = ts_t'($urandom_range(0, 1000));
    for (int unsigned i = 0; i < FILL_ITEMS; i++) begin
      ts = ts + ts_t'($urandom_range(1, 50));
      send_sample(KIND_PUSH, ts);
    end
    finish_phase();
    idle_on = 1'b1;
  endtask

  task automatic test_random_phases();
    ts_t               window;
    ts_t               cur_ts;
    int unsigned       step_max;
    int unsigned       r;
    logic [63:0]       rate_est;
    logic [RATE_W-1:0] nominal;
    logic [FRAC_W-1:0] fraction;
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: window = '0;
        1: window = 32'd1;
        2: window = ts_t'($urandom_range(2, 300));
        3, 4: window = ts_t'($urandom_range(300, 200000));
        default: window = $urandom;
      endcase
      if (window < 8) step_max = $urandom_range(2, 64);
      else step_max = window / $urandom_range(2, 64) + 2;
      rate_est = 64'd2000000000 / 64'(step_max + 1);
      case ($urandom_range(0, 5))
        0: nominal = '0;
        1: nominal = RATE_W'({$urandom, $urandom});
        default: nominal = RATE_W'(rate_est * $urandom_range(1, 3));
      endcase
      fraction = ($urandom_range(0, 5) == 0) ? '0 : FRAC_W'($urandom_range(1, 65535));
      idle_on = ($urandom_range(0, 3) != 0);
      write_regs(window, nominal, fraction);
      cur_ts = $urandom;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 84) begin
          cur_ts = cur_ts + ts_t'($urandom_range(1, step_max));
          send_sample(KIND_PUSH, cur_ts);
        end else if (r < 90) begin
          send_sample(KIND_PUSH, cur_ts);
        end else if (r < 94) begin
          cur_ts = cur_ts - ts_t'($urandom_range(1, step_max));
          send_sample(KIND_PUSH, cur_ts);
        end else if (r < 97) begin
          send_sample(KIND_CLEAR, $urandom);
        end else begin
          cur_ts = $urandom;
          send_sample(KIND_PUSH, cur_ts);
        end
      end
      finish_phase();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    sample_if.valid = 1'b0;
    sample_if.kind = KIND_PUSH;
    sample_if.timestamp = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_WINDOW;
    cfg_if.data = '0;
    win_ticks = WINDOW_RESET;
    nominal_mhz = '0;
    frac_q16 = '0;
    ring_head = 0;
    ring_fill = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_register_extremes();
    test_store_full();
    test_random_phases();

    finish_phase();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results missing", 64'(expected_results.size()), 64'd0);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/swrm_pkg.sv
src/swrm_if.sv
src/swrm_ram.sv
src/swrm_div.sv
src/sliding_window_rate_monitor_core.sv
tb/sv/testbench.sv
